[design/pptd_pkg.sv]
// ----------------------------------------------------------------------------
// pptd_pkg
// Shared types, codes and reset values for the priority task dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package pptd_pkg;

  localparam int NUM_TASKS_DEF  = 4;
  localparam int TIME_BITS_DEF  = 32;
  localparam int PRIO_BITS      = 2;
  localparam int PERIOD_BITS    = 9;
  localparam int RUN_BITS       = 32;
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = PERIOD_BITS;
  localparam int TASK_OUT_BITS  = 2;
  localparam int MASK_BITS      = 4;

  localparam logic [PERIOD_BITS-1:0] PERIOD_SHORT = PERIOD_BITS'(5);
  localparam logic [PERIOD_BITS-1:0] PERIOD_MID   = PERIOD_BITS'(10);
  localparam logic [PERIOD_BITS-1:0] PERIOD_LONG  = PERIOD_BITS'(15);
  localparam logic [PRIO_BITS-1:0]   PRIO_LOWEST  = '1;

  typedef enum logic [1:0] {
    ST_READY   = 2'd0,
    ST_RUNNING = 2'd1,
    ST_IDLE    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_COMPLETE   = 2'd1,
    OP_RESCHEDULE = 2'd2
  } op_t;

  typedef struct packed {
    logic                     running_valid;
    logic [TASK_OUT_BITS-1:0] running_task;
    logic                     dispatched;
    logic                     preempted;
    logic [TASK_OUT_BITS-1:0] preempted_task;
    logic [MASK_BITS-1:0]     ready_mask;
    logic [RUN_BITS-1:0]      completed_runs;
  } result_t;

  function automatic logic [PRIO_BITS-1:0] prio_reset(input int k);
    return (k < 4) ? PRIO_BITS'(k) : PRIO_LOWEST;
  endfunction

  function automatic logic [PERIOD_BITS-1:0] period_reset(input int k);
    return (k == 0) ? PERIOD_SHORT : ((k == 2) ? PERIOD_LONG : PERIOD_MID);
  endfunction

endpackage

`default_nettype wire

[design/pptd_sched.sv]
// ----------------------------------------------------------------------------
// pptd_sched
// Next-state and result logic for one dispatcher transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module pptd_sched #(
  parameter int NUM_TASKS = pptd_pkg::NUM_TASKS_DEF,
  parameter int TIME_BITS = pptd_pkg::TIME_BITS_DEF,
  localparam int IDX_BITS = $clog2(NUM_TASKS)
) (
  input  pptd_pkg::op_t                          op,
  input  logic [TIME_BITS-1:0]                   now,
  input  pptd_pkg::status_t                      status        [NUM_TASKS],
  input  logic [TIME_BITS-1:0]                   last_start    [NUM_TASKS],
  input  logic [TIME_BITS-1:0]                   dispatch_time [NUM_TASKS],
  input  logic [pptd_pkg::RUN_BITS-1:0]          run_count     [NUM_TASKS],
  input  logic [pptd_pkg::PRIO_BITS-1:0]         prio          [NUM_TASKS],
  input  logic [pptd_pkg::PERIOD_BITS-1:0]       period        [NUM_TASKS],
  input  logic                                   active,
  input  logic [IDX_BITS-1:0]                    cur,
  output pptd_pkg::status_t                      status_next        [NUM_TASKS],
  output logic [TIME_BITS-1:0]                   last_start_next    [NUM_TASKS],
  output logic [TIME_BITS-1:0]                   dispatch_time_next [NUM_TASKS],
  output logic [pptd_pkg::RUN_BITS-1:0]          run_count_next     [NUM_TASKS],
  output logic                                   active_next,
  output logic [IDX_BITS-1:0]                    cur_next,
  output pptd_pkg::result_t                      result_next
);

  localparam int MASK_TASKS = (NUM_TASKS < pptd_pkg::MASK_BITS) ? NUM_TASKS
                                                                  : pptd_pkg::MASK_BITS;

  pptd_pkg::status_t                st_tick [NUM_TASKS];
  pptd_pkg::status_t                st_pre  [NUM_TASKS];
  logic [TIME_BITS-1:0]             elapsed [NUM_TASKS];
  logic                             higher;
  logic                             found;
  logic [IDX_BITS-1:0]              best;
  logic [pptd_pkg::PRIO_BITS-1:0]   best_prio;
  logic [pptd_pkg::RUN_BITS-1:0]    count_inc;
  logic                             preempt;
  logic [IDX_BITS+1:0]              cur_wide;
  logic [IDX_BITS+1:0]              cur_next_wide;

  // idle tasks whose period has run out become ready
  always_comb begin
    for (int i = 0; i < NUM_TASKS; i++) begin
      elapsed[i] = now - last_start[i];
      st_tick[i] = status[i];
      if (status[i] == pptd_pkg::ST_IDLE &&
          elapsed[i] >= {{(TIME_BITS-pptd_pkg::PERIOD_BITS){1'b0}}, period[i]}) begin
        st_tick[i] = pptd_pkg::ST_READY;
      end
    end
  end

  // preemption check against the running task
  always_comb begin
    higher = 1'b0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (st_tick[i] == pptd_pkg::ST_READY && prio[i] < prio[cur]) begin
        higher = 1'b1;
      end
    end
    preempt = active && higher;
    st_pre  = st_tick;
    if (preempt) begin
      st_pre[cur] = pptd_pkg::ST_READY;
    end
  end

  // highest priority ready task, later index wins ties
  always_comb begin
    found     = 1'b0;
    best      = '0;
    best_prio = '0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      if (st_pre[i] == pptd_pkg::ST_READY && (!found || prio[i] <= best_prio)) begin
        found     = 1'b1;
        best      = IDX_BITS'(i);
        best_prio = prio[i];
      end
    end
  end

  assign count_inc = (run_count[cur] == '1) ? run_count[cur] : run_count[cur] + 1'b1;
  assign cur_wide  = {2'b00, cur};

  always_comb begin
    status_next        = status;
    last_start_next    = last_start;
    dispatch_time_next = dispatch_time;
    run_count_next     = run_count;
    active_next        = active;
    cur_next           = cur;
    result_next        = '0;
    case (op)
      pptd_pkg::OP_TICK: begin
        status_next = st_pre;
        active_next = active && !higher;
        if (preempt) begin
          result_next.preempted      = 1'b1;
          result_next.preempted_task = cur_wide[pptd_pkg::TASK_OUT_BITS-1:0];
        end
        if (!(active && !higher) && found) begin
          status_next[best]        = pptd_pkg::ST_RUNNING;
          dispatch_time_next[best] = now;
          active_next              = 1'b1;
          cur_next                 = best;
          result_next.dispatched   = 1'b1;
        end
      end
      pptd_pkg::OP_COMPLETE: begin
        if (active) begin
          status_next[cur]           = pptd_pkg::ST_IDLE;
          last_start_next[cur]       = dispatch_time[cur];
          run_count_next[cur]        = count_inc;
          result_next.completed_runs = count_inc;
          active_next                = 1'b0;
        end
      end
      pptd_pkg::OP_RESCHEDULE: begin
        if (active) begin
          result_next.preempted      = 1'b1;
          result_next.preempted_task = cur_wide[pptd_pkg::TASK_OUT_BITS-1:0];
        end
        active_next = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++) begin
          status_next[i] = pptd_pkg::ST_READY;
        end
      end
      default: begin
      end
    endcase
    cur_next_wide = {2'b00, cur_next};
    result_next.running_valid = active_next;
    result_next.running_task  = active_next ? cur_next_wide[pptd_pkg::TASK_OUT_BITS-1:0]
                                            : '0;
    for (int i = 0; i < MASK_TASKS; i++) begin
      result_next.ready_mask[i] = (status_next[i] == pptd_pkg::ST_READY);
    end
  end

endmodule

`default_nettype wire

[design/preemptive_priority_task_dispatcher.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_task_dispatcher
// Fixed-priority preemptive dispatcher for a set of periodic tasks.
// ----------------------------------------------------------------------------
// The block takes one transaction in every clock cycle: busy stays low, and a
// start pulse is captured in an input register. The result is then registered
// in the result register and shown on the result ports with done high for
// exactly one cycle; the receiver has no way to hold it, so it must take
// every result as it appears. The per-task elapsed-time compare, the
// preemption check and the priority search all settle in combinational logic
// between the input register and the result register. Configuration writes
// are always accepted and take effect on the next transaction.
`default_nettype none

module preemptive_priority_task_dispatcher #(
  parameter int NUM_TASKS = pptd_pkg::NUM_TASKS_DEF,
  parameter int TIME_BITS = pptd_pkg::TIME_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  output logic                                    busy,
  input  logic [1:0]                              operation,
  input  logic [TIME_BITS-1:0]                    now_seconds,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [pptd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [pptd_pkg::CFG_DATA_BITS-1:0]      cfg_data,
  output logic                                    done,
  output logic                                    running_valid,
  output logic [pptd_pkg::TASK_OUT_BITS-1:0]      running_task,
  output logic                                    dispatched,
  output logic                                    preempted,
  output logic [pptd_pkg::TASK_OUT_BITS-1:0]      preempted_task,
  output logic [pptd_pkg::MASK_BITS-1:0]          ready_mask,
  output logic [pptd_pkg::RUN_BITS-1:0]           completed_runs
);

  localparam int IDX_BITS = $clog2(NUM_TASKS);

  logic                              in_valid;
  pptd_pkg::op_t                     in_op;
  logic [TIME_BITS-1:0]              in_now;

  logic [pptd_pkg::PRIO_BITS-1:0]    prio          [NUM_TASKS];
  logic [pptd_pkg::PERIOD_BITS-1:0]  period        [NUM_TASKS];
  pptd_pkg::status_t                 status        [NUM_TASKS];
  logic [TIME_BITS-1:0]              last_start    [NUM_TASKS];
  logic [TIME_BITS-1:0]              dispatch_time [NUM_TASKS];
  logic [pptd_pkg::RUN_BITS-1:0]     run_count     [NUM_TASKS];
  logic                              active;
  logic [IDX_BITS-1:0]               cur;
  pptd_pkg::result_t                 result;

  pptd_pkg::status_t                 status_next        [NUM_TASKS];
  logic [TIME_BITS-1:0]              last_start_next    [NUM_TASKS];
  logic [TIME_BITS-1:0]              dispatch_time_next [NUM_TASKS];
  logic [pptd_pkg::RUN_BITS-1:0]     run_count_next     [NUM_TASKS];
  logic                              active_next;
  logic [IDX_BITS-1:0]               cur_next;
  pptd_pkg::result_t                 result_next;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_op  <= pptd_pkg::op_t'(operation);
      in_now <= now_seconds;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        prio[k]   <= pptd_pkg::prio_reset(k);
        period[k] <= pptd_pkg::period_reset(k);
      end
    end else if (cfg_valid && cfg_ready) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        if (cfg_index == pptd_pkg::CFG_INDEX_BITS'(k)) begin
          prio[k] <= cfg_data[pptd_pkg::PRIO_BITS-1:0];
        end
        if (cfg_index == pptd_pkg::CFG_INDEX_BITS'(NUM_TASKS + k)) begin
          period[k] <= cfg_data[pptd_pkg::PERIOD_BITS-1:0];
        end
      end
    end
  end

  pptd_sched #(
    .NUM_TASKS (NUM_TASKS),
    .TIME_BITS (TIME_BITS)
  ) u_sched (
    .op                 (in_op),
    .now                (in_now),
    .status             (status),
    .last_start         (last_start),
    .dispatch_time      (dispatch_time),
    .run_count          (run_count),
    .prio               (prio),
    .period             (period),
    .active             (active),
    .cur                (cur),
    .status_next        (status_next),
    .last_start_next    (last_start_next),
    .dispatch_time_next (dispatch_time_next),
    .run_count_next     (run_count_next),
    .active_next        (active_next),
    .cur_next           (cur_next),
    .result_next        (result_next)
  );

  // task state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_TASKS; k++) begin
        status[k]        <= pptd_pkg::ST_READY;
        last_start[k]    <= '0;
        dispatch_time[k] <= '0;
        run_count[k]     <= '0;
      end
      active <= 1'b0;
      cur    <= '0;
      done   <= 1'b0;
    end else begin
      done <= in_valid;
      if (in_valid) begin
        status        <= status_next;
        last_start    <= last_start_next;
        dispatch_time <= dispatch_time_next;
        run_count     <= run_count_next;
        active        <= active_next;
        cur           <= cur_next;
      end
    end
    if (in_valid) begin
      result <= result_next;
    end
  end

  assign running_valid  = result.running_valid;
  assign running_task   = result.running_task;
  assign dispatched     = result.dispatched;
  assign preempted      = result.preempted;
  assign preempted_task = result.preempted_task;
  assign ready_mask     = result.ready_mask;
  assign completed_runs = result.completed_runs;

endmodule

`default_nettype wire

[design/pptd_checker.sv]
// ----------------------------------------------------------------------------
// pptd_checker
// Port-level checks for the priority task dispatcher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pptd_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                start,
  input wire logic                                busy,
  input wire logic                                done,
  input wire logic                                running_valid,
  input wire logic [pptd_pkg::TASK_OUT_BITS-1:0]  running_task,
  input wire logic                                dispatched,
  input wire logic                                preempted,
  input wire logic [pptd_pkg::TASK_OUT_BITS-1:0]  preempted_task,
  input wire logic [pptd_pkg::RUN_BITS-1:0]       completed_runs
);

  // every accepted transaction is followed by a result
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted transaction produced no result");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result without an accepted transaction");

  a_dispatch_runs: assert property (@(posedge clk) disable iff (rst)
    (done && dispatched) |-> running_valid)
    else $error("dispatch reported with no running task");

  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    (done && (!running_valid || !preempted)) |->
      ((running_valid || running_task == '0) && (preempted || preempted_task == '0)))
    else $error("task index reported without its flag");

  a_completion_alone: assert property (@(posedge clk) disable iff (rst)
    (done && completed_runs != '0) |-> (!running_valid && !dispatched && !preempted))
    else $error("completion mixed with other events");

endmodule

bind preemptive_priority_task_dispatcher pptd_checker u_pptd_checker (.*);

`default_nettype wire

[tb/pptd_schedule_checker.sv]
// ----------------------------------------------------------------------------
// pptd_schedule_checker
// Watches the command, configuration and result channels of the priority task
// dispatcher. It keeps its own copy of the task table and the priority and
// period registers, works out the schedule that each accepted command should
// produce, and compares every result field with the oldest pending schedule.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pptd_schedule_checker
  import pptd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      busy,
  input  logic [1:0]                operation,
  input  logic [31:0]               now_seconds,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                      done,
  input  logic                      running_valid,
  input  logic [TASK_OUT_BITS-1:0]  running_task,
  input  logic                      dispatched,
  input  logic                      preempted,
  input  logic [TASK_OUT_BITS-1:0]  preempted_task,
  input  logic [MASK_BITS-1:0]      ready_mask,
  input  logic [RUN_BITS-1:0]       completed_runs,
  output int                        mismatches,
  output int                        outstanding
);

  localparam int TASKS = NUM_TASKS_DEF;

  logic [PRIO_BITS-1:0]   task_prio [TASKS];
  logic [PERIOD_BITS-1:0] task_period [TASKS];
  status_t                task_state [TASKS];
  logic [31:0]            last_start [TASKS];
  logic [31:0]            dispatch_time [TASKS];
  logic [RUN_BITS-1:0]    run_total [TASKS];
  logic                   cpu_taken;
  logic [1:0]             cpu_owner;

  result_t sched_queue[$];
  result_t oldest;
  int      err_count = 0;
  int      pending = 0;

  assign mismatches  = err_count;
  assign outstanding = pending;

  task automatic clear_tasks();
    for (int i = 0; i < TASKS; i++) begin
      task_prio[i]     = PRIO_BITS'(i);
      task_period[i]   = (i == 0) ? PERIOD_SHORT : ((i == 2) ? PERIOD_LONG : PERIOD_MID);
      task_state[i]    = ST_READY;
      last_start[i]    = '0;
      dispatch_time[i] = '0;
      run_total[i]     = '0;
    end
    cpu_taken = 1'b0;
    cpu_owner = '0;
  endtask

  task automatic apply_setting(input logic [CFG_INDEX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] value);
    if (idx < TASKS)
      task_prio[2'(idx)] = value[PRIO_BITS-1:0];
    else if (idx < 2 * TASKS)
      task_period[2'(idx - TASKS)] = value;
  endtask

  function automatic result_t schedule_step(input logic [1:0] op, input logic [31:0] stamp);
    result_t             r;
    logic [31:0]         elapsed;
    logic                higher;
    logic                found;
    logic [1:0]          best;
    logic [PRIO_BITS-1:0] best_prio;
    r = '0;
    if (op == OP_TICK) begin
      for (int i = 0; i < TASKS; i++) begin
        elapsed = stamp - last_start[i];
        if (task_state[i] == ST_IDLE && elapsed >= 32'(task_period[i]))
          task_state[i] = ST_READY;
      end
      if (cpu_taken) begin
        higher = 1'b0;
        for (int i = 0; i < TASKS; i++)
          if (task_state[i] == ST_READY && task_prio[i] < task_prio[cpu_owner])
            higher = 1'b1;
        if (higher) begin
          task_state[cpu_owner] = ST_READY;
          r.preempted      = 1'b1;
          r.preempted_task = cpu_owner;
          cpu_taken        = 1'b0;
        end
      end
      if (!cpu_taken) begin
        found     = 1'b0;
        best      = '0;
        best_prio = '0;
        // equal priority goes to the higher task index
        for (int i = 0; i < TASKS; i++)
          if (task_state[i] == ST_READY && (!found || task_prio[i] <= best_prio)) begin
            found     = 1'b1;
            best      = 2'(i);
            best_prio = task_prio[i];
          end
        if (found) begin
          task_state[best]    = ST_RUNNING;
          dispatch_time[best] = stamp;
          cpu_taken           = 1'b1;
          cpu_owner           = best;
          r.dispatched        = 1'b1;
        end
      end
    end else if (op == OP_COMPLETE) begin
      if (cpu_taken) begin
        task_state[cpu_owner] = ST_IDLE;
        last_start[cpu_owner] = dispatch_time[cpu_owner];
        if (run_total[cpu_owner] != '1)
          run_total[cpu_owner] = run_total[cpu_owner] + 1'b1;
        r.completed_runs = run_total[cpu_owner];
        cpu_taken        = 1'b0;
      end
    end else if (op == OP_RESCHEDULE) begin
      if (cpu_taken) begin
        r.preempted      = 1'b1;
        r.preempted_task = cpu_owner;
        cpu_taken        = 1'b0;
      end
      for (int i = 0; i < TASKS; i++)
        task_state[i] = ST_READY;
    end
    r.running_valid = cpu_taken;
    r.running_task  = cpu_taken ? cpu_owner : '0;
    for (int i = 0; i < TASKS; i++)
      r.ready_mask[i] = (task_state[i] == ST_READY);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tasks();
      sched_queue.delete();
    end else begin
      if (done) begin
        if (sched_queue.size() == 0) begin
          err_count++;
          $display("%0t: result with no transaction pending", $time);
        end else begin
          oldest = sched_queue.pop_front();
          check_field("running_valid", 32'(oldest.running_valid), 32'(running_valid));
          check_field("running_task", 32'(oldest.running_task), 32'(running_task));
          check_field("dispatched", 32'(oldest.dispatched), 32'(dispatched));
          check_field("preempted", 32'(oldest.preempted), 32'(preempted));
          check_field("preempted_task", 32'(oldest.preempted_task), 32'(preempted_task));
          check_field("ready_mask", 32'(oldest.ready_mask), 32'(ready_mask));
          check_field("completed_runs", oldest.completed_runs, completed_runs);
        end
      end
      if (cfg_valid && cfg_ready)
        apply_setting(cfg_index, cfg_data);
      if (start && !busy)
        sched_queue.push_back(schedule_step(operation, now_seconds));
    end
    pending = sched_queue.size();
  end

endmodule

[tb/preemptive_priority_task_dispatcher_tb.sv]
// ----------------------------------------------------------------------------
// preemptive_priority_task_dispatcher_tb
// Drives the priority task dispatcher with a directed opening (idle
// completion, unused code, preemption, reschedule, time wrap, priority ties,
// zero and maximum periods) followed by random phases of ticks, completions
// and reschedules under several priority/period configurations and idle
// rates. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module preemptive_priority_task_dispatcher_tb;
  import pptd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int REG_PRIO_BASE   = 0;
  localparam int REG_PERIOD_BASE = NUM_TASKS_DEF;
  localparam int REG_UNMAPPED    = 2 * NUM_TASKS_DEF;
  localparam int REG_LAST        = (1 << CFG_INDEX_BITS) - 1;
  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 4;
  localparam int PHASE_ITEMS     = 280;

  typedef enum int {
    PROFILE_MIXED,
    PROFILE_ALL_TOP,
    PROFILE_ALL_BOTTOM,
    PROFILE_WIDE
  } profile_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [1:0]                operation;
  logic [31:0]               now_seconds;
  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      done;
  logic                      running_valid;
  logic [TASK_OUT_BITS-1:0]  running_task;
  logic                      dispatched;
  logic                      preempted;
  logic [TASK_OUT_BITS-1:0]  preempted_task;
  logic [MASK_BITS-1:0]      ready_mask;
  logic [RUN_BITS-1:0]       completed_runs;

  int          mismatches;
  int          outstanding;
  int          idle_pct = 0;
  int          quiet_cycles = 0;
  logic [31:0] wall_clock = '0;

  preemptive_priority_task_dispatcher u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .now_seconds    (now_seconds),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .running_valid  (running_valid),
    .running_task   (running_task),
    .dispatched     (dispatched),
    .preempted      (preempted),
    .preempted_task (preempted_task),
    .ready_mask     (ready_mask),
    .completed_runs (completed_runs)
  );

  pptd_schedule_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .operation      (operation),
    .now_seconds    (now_seconds),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .running_valid  (running_valid),
    .running_task   (running_task),
    .dispatched     (dispatched),
    .preempted      (preempted),
    .preempted_task (preempted_task),
    .ready_mask     (ready_mask),
    .completed_runs (completed_runs),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("preemptive_priority_task_dispatcher verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_command(input logic [1:0] op, input logic [31:0] stamp);
    start       <= 1'b1;
    operation   <= op;
    now_seconds <= stamp;
    @(posedge clk);
    while (busy) @(posedge clk);
    while ($urandom_range(99) < idle_pct) begin
      start       <= 1'b0;
      operation   <= 2'($urandom);
      now_seconds <= $urandom;
      @(posedge clk);
    end
  endtask

  task automatic write_setting(input int idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_INDEX_BITS'(idx);
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // stop sending and wait until every pending transaction has returned
  task automatic settle();
    start     <= 1'b0;
    cfg_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_settings(input profile_t profile);
    logic [PRIO_BITS-1:0]   pr;
    logic [PERIOD_BITS-1:0] pe;
    for (int k = 0; k < NUM_TASKS_DEF; k++) begin
      case (profile)
        PROFILE_MIXED: begin
          pr = PRIO_BITS'($urandom_range(3));
          pe = PERIOD_BITS'($urandom_range(1, 40));
        end
        PROFILE_ALL_TOP: begin
          pr = '0;
          pe = PERIOD_BITS'($urandom_range(1));
        end
        PROFILE_ALL_BOTTOM: begin
          pr = '1;
          pe = k[0] ? '1 : PERIOD_BITS'(300);
        end
        default: begin
          pr = PRIO_BITS'($urandom_range(3));
          pe = ($urandom_range(7) == 0) ? PERIOD_BITS'($urandom) :
                                          PERIOD_BITS'($urandom_range(25));
        end
      endcase
      // upper data bits are don't-care for priority registers
      write_setting(REG_PRIO_BASE + k, {7'($urandom), pr});
      write_setting(REG_PERIOD_BASE + k, pe);
    end
    settle();
  endtask

  task automatic run_phase(input int items, input int step_max);
    int         pick;
    logic [1:0] op;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2)
        settle();
      pick = $urandom_range(99);
      if (pick < 55) begin
        wall_clock = wall_clock + 32'($urandom_range(step_max));
        op = OP_TICK;
      end else if (pick < 85) begin
        op = OP_COMPLETE;
      end else if (pick < 92) begin
        op = OP_RESCHEDULE;
      end else if (pick < 95) begin
        op = OP_UNUSED;
      end else begin
        wall_clock = $urandom;
        op = OP_TICK;
      end
      send_command(op, (op == OP_TICK) ? wall_clock : $urandom);
    end
    settle();
  endtask

  initial begin
    rst         <= 1'b1;
    start       <= 1'b0;
    operation   <= '0;
    now_seconds <= '0;
    cfg_valid   <= 1'b0;
    cfg_index   <= '0;
    cfg_data    <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // reset settings: distinct priorities, preemption and time wrap
    send_command(OP_COMPLETE, 32'd7);
    send_command(OP_UNUSED, '1);
    send_command(OP_TICK, 32'd0);
    send_command(OP_COMPLETE, 32'd0);
    send_command(OP_TICK, 32'd1);
    send_command(OP_TICK, 32'd5);
    send_command(OP_RESCHEDULE, 32'd6);
    send_command(OP_TICK, 32'hFFFF_FFFF);
    send_command(OP_COMPLETE, 32'd0);
    send_command(OP_TICK, 32'd3);
    send_command(OP_TICK, 32'd4);
    send_command(OP_COMPLETE, 32'd4);
    send_command(OP_COMPLETE, 32'd4);
    settle();

    // equal priorities, zero and maximum periods, unmapped indexes
    for (int k = 0; k < NUM_TASKS_DEF; k++)
      write_setting(REG_PRIO_BASE + k, CFG_DATA_BITS'(PRIO_LOWEST - 1'b1));
    write_setting(REG_PERIOD_BASE, '0);
    write_setting(REG_PERIOD_BASE + 1, '1);
    write_setting(REG_PERIOD_BASE + 2, PERIOD_BITS'(1));
    write_setting(REG_PERIOD_BASE + 3, PERIOD_BITS'(300));
    write_setting(REG_UNMAPPED, '1);
    write_setting(REG_LAST, '0);
    settle();
    send_command(OP_RESCHEDULE, 32'd100);
    send_command(OP_TICK, 32'd100);
    send_command(OP_COMPLETE, 32'd100);
    send_command(OP_TICK, 32'd100);
    send_command(OP_COMPLETE, 32'd100);
    send_command(OP_TICK, 32'd101);
    send_command(OP_COMPLETE, 32'd101);
    send_command(OP_TICK, 32'd101);
    send_command(OP_COMPLETE, 32'd101);
    send_command(OP_TICK, 32'd101);
    settle();

    program_settings(PROFILE_MIXED);
    idle_pct = 0;
    run_phase(PHASE_ITEMS, 12);
    program_settings(PROFILE_ALL_TOP);
    idle_pct = 82;
    run_phase(PHASE_ITEMS, 4);
    program_settings(PROFILE_ALL_BOTTOM);
    idle_pct = 33;
    run_phase(PHASE_ITEMS, 200);
    program_settings(PROFILE_WIDE);
    idle_pct = 0;
    run_phase(PHASE_ITEMS, 15);
    program_settings(PROFILE_MIXED);
    idle_pct = 82;
    run_phase(PHASE_ITEMS, 20);

    settle();
    if (mismatches == 0)
      $display("preemptive_priority_task_dispatcher verification clean");
    else
      $display("preemptive_priority_task_dispatcher verification failed");
    $finish;
  end

endmodule

[preemptive_priority_task_dispatcher.f]
design/pptd_pkg.sv
design/pptd_sched.sv
design/preemptive_priority_task_dispatcher.sv
design/pptd_checker.sv
tb/pptd_schedule_checker.sv
tb/preemptive_priority_task_dispatcher_tb.sv
